// ----- hdl/ppf_pkg.sv -----
// ppf_pkg: shared types, constants and helpers of the PPM frame decoder.
// No dependencies; imported by every module of the block.
package ppf_pkg;

  localparam int CHANNELS = 8;
  localparam int SLOT_W   = $clog2(CHANNELS);
  localparam int PTR_W    = $clog2(CHANNELS + 1);

  localparam int CMD_W    = 2;
  localparam int EDGE_W   = 16;
  localparam int STAMP_W  = 63;
  localparam int INDEX_W  = 3;
  localparam int WIDTH_W  = 15;
  localparam int PERIOD_W = 17;
  localparam int COUNT_W  = 4;

  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [WIDTH_W-1:0]  MIN_RESET          = 15'd32767;
  localparam logic [WIDTH_W-1:0]  SYNC_GAP_RESET     = 15'd2100;
  localparam logic [PERIOD_W-1:0] TIMER_PERIOD_RESET = 17'd60000;
  localparam logic [PTR_W-1:0]    CHAN_LIMIT         = PTR_W'(CHANNELS);

  // two-entry queues, for requests and for results
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;
  localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);

  typedef enum logic {
    REG_SYNC_GAP     = 1'b0,
    REG_TIMER_PERIOD = 1'b1
  } reg_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_EDGE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SYNC,
    OP_PULSE,
    OP_READ,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [WIDTH_W-1:0] width;
    logic [STAMP_W-1:0] stamp;
    logic [INDEX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [WIDTH_W-1:0] min;
    logic [WIDTH_W-1:0] max;
    logic [STAMP_W-1:0] stamp;
    logic [COUNT_W-1:0] count;
    logic               valid;
  } res_t;

  // slot order 0,1,2,3,5,4,6,7
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(3)) begin
      n = PTR_W'(5);
    end else if (p == PTR_W'(5)) begin
      n = PTR_W'(4);
    end else if (p == PTR_W'(4)) begin
      n = PTR_W'(6);
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

endpackage

// ----- hdl/ppm_frame_decoder.sv -----
// ppm_frame_decoder: top level, configuration registers and the two halves.
// Depends on ppf_pkg, ppf_front and ppf_back.
//
//   channel  | handshake          | carries
//   ---------+--------------------+-------------------------------------------
//   request  | push / full        | command, edge_time, system_time, index
//   result   | empty / pop        | width, min, max, update_time, count, valid
//   config   | APB psel/penable   | sync_gap @0x0, timer_period @0x4
//
// One request per cycle while full is low; a result passes the front queue, then the
// result queue, before it reaches the result ports and can be popped.
// Reset is asynchronous; stores and registers take their initial values at once.
// A stalled result side fills the result queue, then the front queue, then full.
module ppm_frame_decoder import ppf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [EDGE_W-1:0]   edge_time_i,
  input  logic [STAMP_W-1:0]  system_time_i,
  input  logic [INDEX_W-1:0]  channel_index_i,
  output logic                empty,
  input  logic                pop,
  output logic [WIDTH_W-1:0]  channel_width_o,
  output logic [WIDTH_W-1:0]  channel_min_o,
  output logic [WIDTH_W-1:0]  channel_max_o,
  output logic [STAMP_W-1:0]  update_time_o,
  output logic [COUNT_W-1:0]  channel_count_o,
  output logic                read_valid_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  logic [WIDTH_W-1:0]  sync_gap_q;
  logic [PERIOD_W-1:0] timer_period_q;
  logic                head_valid, take;
  req_t                head;
  res_t                res;
  reg_e                reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_gap_q     <= SYNC_GAP_RESET;
      timer_period_q <= TIMER_PERIOD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_SYNC_GAP:     sync_gap_q     <= pwdata[WIDTH_W-1:0];
        REG_TIMER_PERIOD: timer_period_q <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SYNC_GAP:     prdata = APB_DW'(sync_gap_q);
      REG_TIMER_PERIOD: prdata = APB_DW'(timer_period_q);
      default:          prdata = '0;
    endcase
  end

  ppf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .edge_time_i     (edge_time_i),
    .system_time_i   (system_time_i),
    .channel_index_i (channel_index_i),
    .sync_gap_i      (sync_gap_q),
    .timer_period_i  (timer_period_q),
    .head_valid_o    (head_valid),
    .head_o          (head),
    .take_i          (take)
  );

  ppf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .take_o       (take),
    .empty        (empty),
    .pop          (pop),
    .res_o        (res)
  );

  assign channel_width_o = res.width;
  assign channel_min_o   = res.min;
  assign channel_max_o   = res.max;
  assign update_time_o   = res.stamp;
  assign channel_count_o = res.count;
  assign read_valid_o    = res.valid;

endmodule

// ----- hdl/ppf_front.sv -----
// ppf_front: accepts requests, measures edge spacing, classifies them.
// Depends on ppf_pkg; feeds a two-entry queue read by ppf_back.
module ppf_front import ppf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [EDGE_W-1:0]   edge_time_i,
  input  logic [STAMP_W-1:0]  system_time_i,
  input  logic [INDEX_W-1:0]  channel_index_i,
  input  logic [WIDTH_W-1:0]  sync_gap_i,
  input  logic [PERIOD_W-1:0] timer_period_i,
  output logic                head_valid_o,
  output req_t                head_o,
  input  logic                take_i
);

  logic [EDGE_W-1:0] prev_q, prev_d;
  logic              primed_q, primed_d;
  logic [QCNT_W-1:0] cnt_q;
  logic [QPTR_W-1:0] wr_q, rd_q;
  req_t              mem_q [QDEPTH];
  req_t              req;
  logic [PERIOD_W-1:0] now_x, prev_x, delta;
  logic              accept;

  assign full   = (cnt_q == QFULL);
  assign accept = push && !full;

  assign now_x  = PERIOD_W'(edge_time_i);
  assign prev_x = PERIOD_W'(prev_q);
  assign delta  = (edge_time_i > prev_q) ? (now_x - prev_x)
                                         : (now_x + timer_period_i - prev_x);

  always_comb begin
    prev_d    = prev_q;
    primed_d  = primed_q;
    req.op    = OP_NONE;
    req.width = delta[WIDTH_W-1:0];
    req.stamp = system_time_i;
    req.index = channel_index_i;
    unique case (cmd_e'(command_i))
      CMD_EDGE: begin
        prev_d   = edge_time_i;
        primed_d = 1'b1;
        if (primed_q) begin
          req.op = (delta > PERIOD_W'(sync_gap_i)) ? OP_SYNC : OP_PULSE;
        end
      end
      CMD_READ:  req.op = OP_READ;
      CMD_CLEAR: req.op = OP_CLEAR;
      CMD_NONE:  req.op = OP_NONE;
      default:   req.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      primed_q <= 1'b0;
      cnt_q    <= '0;
      wr_q     <= '0;
      rd_q     <= '0;
    end else begin
      if (accept) begin
        prev_q   <= prev_d;
        primed_q <= primed_d;
        wr_q     <= wr_q + QPTR_W'(1);
      end
      if (take_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(accept) - QCNT_W'(take_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[wr_q] <= req;
    end
  end

  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

endmodule

// ----- hdl/ppf_back.sv -----
// ppf_back: applies classified requests to the channel stores, builds results.
// Depends on ppf_pkg; holds the two-entry result queue seen at the output.
module ppf_back import ppf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic head_valid_i,
  input  req_t head_i,
  output logic take_o,
  output logic empty,
  input  logic pop,
  output res_t res_o
);

  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic [PTR_W-1:0]   frame_q, frame_d;
  logic [WIDTH_W-1:0] width_q [CHANNELS];
  logic [WIDTH_W-1:0] width_d [CHANNELS];
  logic [WIDTH_W-1:0] min_q   [CHANNELS];
  logic [WIDTH_W-1:0] min_d   [CHANNELS];
  logic [WIDTH_W-1:0] max_q   [CHANNELS];
  logic [WIDTH_W-1:0] max_d   [CHANNELS];
  logic [STAMP_W-1:0] stamp_q [CHANNELS];
  logic [STAMP_W-1:0] stamp_d [CHANNELS];
  logic [SLOT_W-1:0]  rd_slot;
  logic [PTR_W-1:0]   idx_x;
  res_t               res;
  logic [QCNT_W-1:0]  cnt_q;
  logic [QPTR_W-1:0]  wr_q, rd_q;
  res_t               mem_q [QDEPTH];
  logic               pop_ok;

  assign pop_ok = pop && (cnt_q != '0);
  assign take_o = head_valid_i && ((cnt_q != QFULL) || pop_ok);
  assign idx_x  = PTR_W'(head_i.index);
  assign rd_slot = (head_i.op == OP_READ) ? SLOT_W'(head_i.index) : ptr_q[SLOT_W-1:0];

  always_comb begin
    ptr_d   = ptr_q;
    frame_d = frame_q;
    width_d = width_q;
    min_d   = min_q;
    max_d   = max_q;
    stamp_d = stamp_q;
    res     = '0;
    if (take_o) begin
      unique case (head_i.op)
        OP_SYNC: begin
          frame_d = ptr_q;
          ptr_d   = '0;
        end
        OP_PULSE: begin
          if (ptr_q < CHAN_LIMIT) begin
            width_d[rd_slot] = head_i.width;
            stamp_d[rd_slot] = head_i.stamp;
            if (head_i.width < min_q[rd_slot]) begin
              min_d[rd_slot] = head_i.width;
            end
            if (head_i.width > max_q[rd_slot]) begin
              max_d[rd_slot] = head_i.width;
            end
            ptr_d = next_slot(ptr_q);
          end
        end
        OP_READ: begin
          if (idx_x < CHAN_LIMIT) begin
            res.width = width_q[rd_slot];
            res.min   = min_q[rd_slot];
            res.max   = max_q[rd_slot];
            res.stamp = stamp_q[rd_slot];
          end
          res.valid = (idx_x < frame_q);
        end
        OP_CLEAR: begin
          for (int i = 0; i < CHANNELS; i++) begin
            min_d[i] = MIN_RESET;
            max_d[i] = '0;
          end
        end
        OP_NONE: ;
        default: ;
      endcase
    end
    res.count = COUNT_W'(frame_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      frame_q <= '0;
      cnt_q   <= '0;
      wr_q    <= '0;
      rd_q    <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        width_q[i] <= '0;
        min_q[i]   <= MIN_RESET;
        max_q[i]   <= '0;
        stamp_q[i] <= '0;
      end
    end else begin
      ptr_q   <= ptr_d;
      frame_q <= frame_d;
      width_q <= width_d;
      min_q   <= min_d;
      max_q   <= max_d;
      stamp_q <= stamp_d;
      if (take_o) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_ok) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(take_o) - QCNT_W'(pop_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      mem_q[wr_q] <= res;
    end
  end

  assign empty = (cnt_q == '0);
  assign res_o = mem_q[rd_q];

endmodule

// ----- hdl/ppf_checker.sv -----
// ppf_checker: port-level checks of the PPM frame decoder, bound to the top.
// Depends on ppf_pkg and ppm_frame_decoder.
module ppf_checker import ppf_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [COUNT_W-1:0] channel_count_o,
  input logic               read_valid_o
);

  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a request");

  a_empty_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(pop))
    else $error("empty rose without a pop");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (channel_count_o <= COUNT_W'(CHANNELS)))
    else $error("channel count above channel total");

  a_valid_needs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && read_valid_o) |-> (channel_count_o != '0))
    else $error("read marked valid with no channels");

endmodule

bind ppm_frame_decoder ppf_checker u_ppf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .push            (push),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .channel_count_o (channel_count_o),
  .read_valid_o    (read_valid_o)
);

// ----- tb/tb_ppm_frame_decoder.sv -----
// tb_ppm_frame_decoder: self-checking testbench of the PPM frame decoder, with its own
// decoder model, random frames, back-pressure and register settings over APB.
// Depends on ppf_pkg and ppm_frame_decoder.
module tb_ppm_frame_decoder;
  import ppf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [CMD_W-1:0]    command_i = '0;
  logic [EDGE_W-1:0]   edge_time_i = '0;
  logic [STAMP_W-1:0]  system_time_i = '0;
  logic [INDEX_W-1:0]  channel_index_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [WIDTH_W-1:0]  channel_width_o;
  logic [WIDTH_W-1:0]  channel_min_o;
  logic [WIDTH_W-1:0]  channel_max_o;
  logic [STAMP_W-1:0]  update_time_o;
  logic [COUNT_W-1:0]  channel_count_o;
  logic                read_valid_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  ppm_frame_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .edge_time_i     (edge_time_i),
    .system_time_i   (system_time_i),
    .channel_index_i (channel_index_i),
    .empty           (empty),
    .pop             (pop),
    .channel_width_o (channel_width_o),
    .channel_min_o   (channel_min_o),
    .channel_max_o   (channel_max_o),
    .update_time_o   (update_time_o),
    .channel_count_o (channel_count_o),
    .read_valid_o    (read_valid_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk_i = ~clk_i;

  // decoder model state
  logic [WIDTH_W-1:0]  gap_cfg;
  logic [PERIOD_W-1:0] period_cfg;
  logic [EDGE_W-1:0]   last_edge;
  logic                edge_seen;
  logic [PTR_W-1:0]    slot_ptr;
  logic [COUNT_W-1:0]  frame_len;
  logic [WIDTH_W-1:0]  width_mem [CHANNELS];
  logic [WIDTH_W-1:0]  min_mem   [CHANNELS];
  logic [WIDTH_W-1:0]  max_mem   [CHANNELS];
  logic [STAMP_W-1:0]  stamp_mem [CHANNELS];

  res_t              pending_q[$];
  int                mismatches = 0;
  int                items_sent = 0;
  int                tx_idle_pct = 35;
  int                rx_idle_pct = 76;
  int                hold_req = 0;
  int                hold_left = 0;
  int                quiet_cycles = 0;
  int unsigned       gen_pos = 0;

  task automatic clear_stats();
    for (int i = 0; i < CHANNELS; i++) begin
      min_mem[i] = MIN_RESET;
      max_mem[i] = '0;
    end
  endtask

  task automatic decode_request(input cmd_e cmd, input logic [EDGE_W-1:0] et,
                                input logic [STAMP_W-1:0] st, input logic [INDEX_W-1:0] ix,
                                output res_t r);
    logic [PERIOD_W-1:0] delta;
    logic [SLOT_W-1:0]   p;
    r = '0;
    case (cmd)
      CMD_EDGE: begin
        if (!edge_seen) begin
          last_edge = et;
          edge_seen = 1'b1;
        end else begin
          if (et > last_edge) delta = {1'b0, et} - {1'b0, last_edge};
          else delta = {1'b0, et} + period_cfg - {1'b0, last_edge};
          last_edge = et;
          if (delta > {2'b0, gap_cfg}) begin
            frame_len = COUNT_W'(slot_ptr);
            slot_ptr  = '0;
          end else if (slot_ptr < PTR_W'(CHANNELS)) begin
            p = slot_ptr[SLOT_W-1:0];
            width_mem[p] = delta[WIDTH_W-1:0];
            if (delta < {2'b0, min_mem[p]}) min_mem[p] = delta[WIDTH_W-1:0];
            if (delta > {2'b0, max_mem[p]}) max_mem[p] = delta[WIDTH_W-1:0];
            stamp_mem[p] = st;
            // channels 4 and 5 swapped
            case (slot_ptr)
              PTR_W'(3): slot_ptr = PTR_W'(5);
              PTR_W'(5): slot_ptr = PTR_W'(4);
              PTR_W'(4): slot_ptr = PTR_W'(6);
              default:   slot_ptr = slot_ptr + PTR_W'(1);
            endcase
          end
        end
      end
      CMD_READ: begin
        r.width = width_mem[ix];
        r.min   = min_mem[ix];
        r.max   = max_mem[ix];
        r.stamp = stamp_mem[ix];
        r.valid = ({1'b0, ix} < frame_len);
      end
      CMD_CLEAR: clear_stats();
      default: ;
    endcase
    r.count = frame_len;
  endtask

  function automatic logic [STAMP_W-1:0] rand_stamp();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[STAMP_W-1:0];
  endfunction

  task automatic send_req(input cmd_e cmd, input logic [EDGE_W-1:0] et,
                          input logic [STAMP_W-1:0] st, input logic [INDEX_W-1:0] ix);
    res_t want;
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push            <= 1'b1;
    command_i       <= cmd;
    edge_time_i     <= et;
    system_time_i   <= st;
    channel_index_i <= ix;
    do @(posedge clk_i); while (full);
    decode_request(cmd, et, st, ix, want);
    pending_q.push_back(want);
    items_sent++;
    if (cmd == CMD_EDGE) gen_pos = et;
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
  endtask

  task automatic apb_write(input reg_e r, input logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_SYNC_GAP:     gap_cfg    = val[WIDTH_W-1:0];
      REG_TIMER_PERIOD: period_cfg = val[PERIOD_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_edge_at(input int unsigned pos);
    send_req(CMD_EDGE, EDGE_W'(pos), rand_stamp(), INDEX_W'($urandom));
  endtask

  // one frame of pulses, mostly closed by a sync gap, with reads and noise mixed in
  task automatic gen_frame();
    int unsigned n, s, wmax, modulus, r;
    modulus = (period_cfg == '0 || period_cfg > 17'd65536) ? 65536 : int'(period_cfg);
    wmax = (int'(gap_cfg) < modulus) ? int'(gap_cfg) : modulus;
    n = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 6)
        send_req(cmd_e'($urandom_range(3)), EDGE_W'($urandom), rand_stamp(),
                 INDEX_W'($urandom));
      else if (r < 18)
        send_req(CMD_READ, EDGE_W'($urandom), rand_stamp(), INDEX_W'($urandom));
      else if (r < 20)
        send_req(CMD_CLEAR, EDGE_W'($urandom), rand_stamp(), INDEX_W'($urandom));
      s = $urandom_range(1, wmax);
      send_edge_at((gen_pos + s) % modulus);
    end
    if (int'(gap_cfg) < modulus && $urandom_range(9) != 0) begin
      s = $urandom_range(int'(gap_cfg) + 1, modulus);
      send_edge_at((gen_pos + s) % modulus);
    end
    send_req(CMD_READ, EDGE_W'($urandom), rand_stamp(), INDEX_W'($urandom));
  endtask

  task automatic test_reset_values();
    send_req(CMD_READ, '0, '0, '0);
    send_req(CMD_NONE, '1, '1, '1);
    send_req(CMD_CLEAR, '0, '0, '0);
  endtask

  task automatic test_frame_decode();
    int unsigned pos;
    int unsigned widths [5] = '{1000, 1200, 1400, 1600, 2100};
    pos = 0;
    send_req(CMD_EDGE, '0, '0, '0);
    foreach (widths[i]) begin
      pos += widths[i];
      send_edge_at(pos);
    end
    // spacing one above the gap; five pulses leave a count of four
    pos += 2101;
    send_edge_at(pos);
    send_req(CMD_READ, '0, '0, 3'd4);
    send_req(CMD_READ, '0, '0, 3'd5);
    // overlong frame, extra pulses dropped
    for (int i = 0; i < 9; i++) begin
      pos += 1500;
      send_req(CMD_EDGE, EDGE_W'(pos), (i == 3) ? '1 : rand_stamp(), '0);
    end
    pos += 3000;
    send_edge_at(pos);
    send_req(CMD_READ, '0, '0, 3'd7);
    // equal edge times give a full period
    send_edge_at(pos);
    send_edge_at(59500);
    send_edge_at(1000);
    send_req(CMD_EDGE, '1, rand_stamp(), '0);
    send_req(CMD_CLEAR, '0, '0, '0);
    send_req(CMD_READ, '0, '0, '0);
  endtask

  task automatic test_config_extremes();
    drain();
    apb_write(REG_SYNC_GAP, 32'd1);
    apb_write(REG_TIMER_PERIOD, 32'd1);
    for (int i = 0; i < 6; i++)
      send_req(CMD_EDGE, EDGE_W'($urandom), rand_stamp(), INDEX_W'($urandom));
    send_req(CMD_READ, '0, '0, INDEX_W'($urandom));
    drain();
    // timer period beyond the 16-bit counter
    apb_write(REG_SYNC_GAP, 32'd32767);
    apb_write(REG_TIMER_PERIOD, 32'h1FFFF);
    for (int i = 0; i < 6; i++)
      send_req(CMD_EDGE, EDGE_W'($urandom), rand_stamp(), INDEX_W'($urandom));
    send_req(CMD_READ, '0, '0, INDEX_W'($urandom));
  endtask

  task automatic test_random_frames(input int tx_pct, input int rx_pct,
                                    input int unsigned gap, input int unsigned period,
                                    input int n);
    int target;
    drain();
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    apb_write(REG_SYNC_GAP, gap);
    apb_write(REG_TIMER_PERIOD, period);
    target = items_sent + n;
    while (items_sent < target) gen_frame();
  endtask

  task automatic test_backpressure();
    int target;
    hold_req = HOLD_CYCLES;
    target = items_sent + 40;
    while (items_sent < target) gen_frame();
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else if (hold_req > 0) begin
      hold_left = hold_req - 1;
      hold_req  = 0;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_q.size() == 0) begin
        $error("result with no request pending");
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        check_field("channel_width", want.width, channel_width_o);
        check_field("channel_min", want.min, channel_min_o);
        check_field("channel_max", want.max, channel_max_o);
        check_field("update_time", want.stamp, update_time_o);
        check_field("channel_count", want.count, channel_count_o);
        check_field("read_valid", want.valid, read_valid_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned gap;
    gap_cfg    = SYNC_GAP_RESET;
    period_cfg = TIMER_PERIOD_RESET;
    last_edge  = '0;
    edge_seen  = 1'b0;
    slot_ptr   = '0;
    frame_len  = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      width_mem[i] = '0;
      stamp_mem[i] = '0;
    end
    clear_stats();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_frame_decode();
    test_config_extremes();
    test_random_frames(35, 76, 2100, 60000, 330);
    test_backpressure();
    test_random_frames(76, 35, 32767, 65536, 330);
    gap = $urandom_range(100, 4000);
    test_random_frames(0, 0, gap, $urandom_range(gap + 1000, 65536), 330);

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ppf_pkg.sv
hdl/ppf_front.sv
hdl/ppf_back.sv
hdl/ppm_frame_decoder.sv
hdl/ppf_checker.sv
tb/tb_ppm_frame_decoder.sv
